[hw/rtl/pwmc_pkg.sv]
// Shared types, constants and the oscillator table of the PWM period/duty calculator.
// Used by every module of the block; depends on nothing.
package pwmc_pkg;

  localparam int FREQ_W   = 20;
  localparam int DUTY_W   = 10;
  localparam int OSC_W    = 24;
  localparam int DEN_W    = 24;  // 2 * 4 * prescale * f
  localparam int NUM_W    = 25;  // 2 * fosc + 4 * prescale * f
  localparam int QUO_W    = 9;   // rounded quotient never exceeds 484
  localparam int PERIOD_W = 8;
  localparam int M_W      = 19;  // (period + 1) * duty
  localparam int RECIP_W  = 13;
  localparam int PROD_W   = M_W + RECIP_W;
  localparam int DUTYQ_W  = PROD_W - 20;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [FREQ_W-1:0]   PRESCALE_LIMIT = 20'd8000;
  localparam logic [FREQ_W-1:0]   SELECT_LIMIT   = 20'd488;
  localparam logic [1:0]          PRESCALE_1     = 2'd0;
  localparam logic [1:0]          PRESCALE_16    = 2'd2;
  localparam logic [2:0]          SEL_FASTEST    = 3'd7;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX     = 8'd255;
  localparam logic [RECIP_W-1:0]  DUTY_RECIP     = 13'd4194;  // floor(2^20 / 250)
  localparam int                  DUTY_SHIFT     = 20;
  localparam logic [M_W-1:0]      DUTY_DIV       = 19'd250;
  localparam logic [DUTY_W-1:0]   DUTY_MAX       = 10'd1023;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency_hz;
    logic [DUTY_W-1:0] duty_tenths;
  } req_t;

  typedef struct packed {
    logic [2:0]          clock_select;
    logic [1:0]          prescale_code;
    logic [PERIOD_W-1:0] period_value;
    logic [DUTY_W-1:0]   duty_value;
    logic                out_of_range;
  } res_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    logic              zero;
    logic [2:0]        sel;
    logic [1:0]        pcode;
    logic [DUTY_W-1:0] duty;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } cls_t;

  function automatic logic [OSC_W-1:0] osc_hz(input logic [2:0] sel);
    logic [OSC_W-1:0] hz;
    case (sel)
      3'd0:    hz = 24'd31000;
      3'd1:    hz = 24'd125000;
      3'd2:    hz = 24'd250000;
      3'd3:    hz = 24'd500000;
      3'd4:    hz = 24'd1000000;
      3'd5:    hz = 24'd2000000;
      3'd6:    hz = 24'd4000000;
      default: hz = 24'd8000000;
    endcase
    return hz;
  endfunction

endpackage

[hw/rtl/pwm_period_duty_calculator.sv]
// Top level of the PWM period/duty calculator: front end, decoupling queue, back end.
// Depends on pwmc_pkg, pwmc_front, pwmc_queue and pwmc_back.
//
// Turns a requested PWM frequency (Hz) and duty cycle (tenths of a percent) into
// timer settings: an oscillator select code, a prescale code (16 below 8000 Hz,
// else 1), an 8-bit period equal to round-half-up(fosc / (4 * prescale * f)) - 1
// clamped to 0..255, and a 10-bit duty compare value floor(4 * (period + 1) *
// duty / 1000) clamped to 1023. out_of_range flags a clamped period or a zero
// frequency; a zero frequency returns all other fields as zero. Requests are
// independent and each gives exactly one result word, in order. Both sides
// look like a queue: push a request word while full is low, pop a result word
// while empty is low. The block takes one word per cycle for as long as results
// are popped; every stage is pipelined: the nine-stage restoring divider retires
// one quotient bit per stage, followed by a clamp stage, a multiply stage and a
// reciprocal-correction stage for the duty value, all advancing together. With
// nothing stalled an accepted request passes through one front register, one
// queue slot, nine divider stages and three back stages to its result. While
// results are not popped the back end holds, the queue (QueueDepth words) fills,
// and full then rises.
module pwm_period_duty_calculator #(
  parameter int QueueDepth = pwmc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  pwmc_pkg::req_t request,
  output logic           empty,
  input  logic           pop,
  output pwmc_pkg::res_t result
);

  // front end to queue
  logic           enq;
  logic           enq_full;
  pwmc_pkg::cls_t enq_word;

  // queue to back end
  logic           deq;
  logic           q_empty;
  pwmc_pkg::cls_t deq_word;

  // Classify the request word and form the divide operands.
  pwmc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .enq      (enq),
    .enq_full (enq_full),
    .cls      (enq_word)
  );

  // Hold classified words so the front keeps accepting while the back stalls.
  pwmc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (enq),
    .full  (enq_full),
    .wdata (enq_word),
    .pop   (deq),
    .empty (q_empty),
    .rdata (deq_word)
  );

  // Divide, clamp the period, scale the duty; drop the word on pop.
  pwmc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .avail  (!q_empty),
    .deq    (deq),
    .cls    (deq_word),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

`ifndef ASSERT_OFF
  // Only the two prescale codes are ever produced.
  a_pcode_legal: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.prescale_code == pwmc_pkg::PRESCALE_1 ||
                result.prescale_code == pwmc_pkg::PRESCALE_16))
    else $error("illegal prescale code on result");

  // Prescale 1 means f >= 8000 (fastest clock, in-range period) or a zero frequency.
  a_fast_path: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.prescale_code == pwmc_pkg::PRESCALE_1) |->
      ((result.clock_select == pwmc_pkg::SEL_FASTEST && !result.out_of_range) ||
       (result.clock_select == '0 && result.period_value == '0 &&
        result.duty_value == '0 && result.out_of_range)))
    else $error("fast-path result with wrong clock or range flag");

  // full can only rise after a word was pushed in the cycle before.
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without a pushed word");
`endif

endmodule

[hw/rtl/pwmc_front.sv]
// Front end: accepts a request word, picks clock and prescale, forms the divide operands.
// Depends on pwmc_pkg.
module pwmc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  pwmc_pkg::req_t  request,
  output logic            enq,
  input  logic            enq_full,
  output pwmc_pkg::cls_t  cls
);

  logic           valid;
  pwmc_pkg::cls_t cls_next;
  logic           accept;

  assign full   = valid && enq_full;
  assign accept = push && !full;
  assign enq    = valid && !enq_full;

  always_comb begin
    logic [pwmc_pkg::FREQ_W-1:0]  f;
    logic [pwmc_pkg::DEN_W-2:0]   den4;
    logic                         slow;
    f    = request.frequency_hz;
    slow = f < pwmc_pkg::PRESCALE_LIMIT;
    cls_next.zero  = (f == '0);
    cls_next.duty  = request.duty_tenths;
    cls_next.pcode = slow ? pwmc_pkg::PRESCALE_16 : pwmc_pkg::PRESCALE_1;
    // thresholds halve per code; a later hit overrides with the faster clock
    cls_next.sel = '0;
    for (int k = 6; k >= 0; k--) begin
      if (f > (pwmc_pkg::SELECT_LIMIT >> k)) begin
        cls_next.sel = 3'(7 - k);
      end
    end
    den4 = slow ? {f[pwmc_pkg::DEN_W-8:0], 6'd0} : {1'b0, f, 2'd0};
    cls_next.den = {den4, 1'b0};
    cls_next.num = {pwmc_pkg::osc_hz(cls_next.sel), 1'b0} + pwmc_pkg::NUM_W'(den4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (enq) begin
      valid <= 1'b0;
    end
    if (accept) begin
      cls <= cls_next;
    end
  end

endmodule

[hw/rtl/pwmc_queue.sv]
// Short register queue that decouples the front end from the back end.
// Depends on pwmc_pkg.
module pwmc_queue #(
  parameter int Depth = pwmc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  pwmc_pkg::cls_t wdata,
  input  logic           pop,
  output logic           empty,
  output pwmc_pkg::cls_t rdata
);

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(Depth - 1);

  pwmc_pkg::cls_t   mem [Depth];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

[hw/rtl/pwmc_back.sv]
// Back end: restoring divider (one quotient bit per stage), period clamp, duty scaling.
// Depends on pwmc_pkg.
module pwmc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  output logic           deq,
  input  pwmc_pkg::cls_t cls,
  output logic           empty,
  input  logic           pop,
  output pwmc_pkg::res_t result
);

  localparam int QW = pwmc_pkg::QUO_W;
  localparam int TW = pwmc_pkg::DEN_W + QW;

  typedef struct packed {
    logic                        zero;
    logic [2:0]                  sel;
    logic [1:0]                  pcode;
    logic [pwmc_pkg::DUTY_W-1:0] duty;
    logic [pwmc_pkg::NUM_W-1:0]  rem;
    logic [pwmc_pkg::DEN_W-1:0]  den;
    logic [QW-1:0]               quo;
  } div_t;

  typedef struct packed {
    logic                          zero;
    logic                          flag;
    logic [2:0]                    sel;
    logic [1:0]                    pcode;
    logic [pwmc_pkg::PERIOD_W-1:0] period;
    logic [pwmc_pkg::M_W-1:0]      m;
  } per_t;

  typedef struct packed {
    per_t                        per;
    logic [pwmc_pkg::PROD_W-1:0] prod;
  } mul_t;

  logic adv;
  div_t div_in  [QW];
  div_t div_out [QW];
  div_t div_r   [QW];
  logic div_v   [QW];
  per_t per_next;
  per_t per_r;
  logic per_v;
  mul_t mul_r;
  logic mul_v;
  pwmc_pkg::res_t res_next;
  logic out_v;

  // whole pipe moves together; it only holds while a finished word waits
  assign adv   = !out_v || pop;
  assign deq   = adv && avail;
  assign empty = !out_v;

  always_comb begin
    div_in[0].zero  = cls.zero;
    div_in[0].sel   = cls.sel;
    div_in[0].pcode = cls.pcode;
    div_in[0].duty  = cls.duty;
    div_in[0].rem   = cls.num;
    div_in[0].den   = cls.den;
    div_in[0].quo   = '0;
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    if (s > 0) begin : g_link
      assign div_in[s] = div_r[s-1];
    end

    always_comb begin
      logic [TW-1:0] diff;
      logic          bit_q;
      diff  = TW'(div_in[s].rem) - (TW'(div_in[s].den) << (QW - 1 - s));
      bit_q = !diff[TW-1];
      div_out[s]     = div_in[s];
      div_out[s].quo = {div_in[s].quo[QW-2:0], bit_q};
      if (bit_q) begin
        div_out[s].rem = diff[pwmc_pkg::NUM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_v[s] <= 1'b0;
      end else if (adv) begin
        div_v[s] <= (s == 0) ? avail : div_v[(s > 0) ? s - 1 : 0];
      end
      if (adv) begin
        div_r[s] <= div_out[s];
      end
    end
  end

  // round-half-up quotient minus one, clamped to the 8-bit period
  always_comb begin
    logic [QW-1:0] q;
    q = div_r[QW-1].quo;
    per_next.zero  = div_r[QW-1].zero;
    per_next.sel   = div_r[QW-1].sel;
    per_next.pcode = div_r[QW-1].pcode;
    per_next.flag  = 1'b0;
    if (q == '0) begin
      per_next.period = '0;
      per_next.flag   = 1'b1;
    end else if (q > QW'({1'b0, pwmc_pkg::PERIOD_MAX}) + 1'b1) begin
      per_next.period = pwmc_pkg::PERIOD_MAX;
      per_next.flag   = 1'b1;
    end else begin
      per_next.period = pwmc_pkg::PERIOD_W'(q - 1'b1);
    end
    per_next.m = (pwmc_pkg::M_W'(per_next.period) + 1'b1) *
                 pwmc_pkg::M_W'(div_r[QW-1].duty);
  end

  // duty = floor(m / 250): reciprocal estimate is exact or one low
  always_comb begin
    logic [pwmc_pkg::DUTYQ_W-1:0] q0;
    logic [pwmc_pkg::M_W-1:0]     r;
    q0 = mul_r.prod[pwmc_pkg::PROD_W-1:pwmc_pkg::DUTY_SHIFT];
    r  = mul_r.per.m - pwmc_pkg::M_W'(q0 * pwmc_pkg::DUTY_DIV);
    if (r >= pwmc_pkg::DUTY_DIV) begin
      q0 = q0 + 1'b1;
    end
    res_next.clock_select  = mul_r.per.sel;
    res_next.prescale_code = mul_r.per.pcode;
    res_next.period_value  = mul_r.per.period;
    res_next.out_of_range  = mul_r.per.flag;
    res_next.duty_value    = (q0 > pwmc_pkg::DUTYQ_W'(pwmc_pkg::DUTY_MAX)) ?
                             pwmc_pkg::DUTY_MAX : q0[pwmc_pkg::DUTY_W-1:0];
    if (mul_r.per.zero) begin
      res_next = '0;
      res_next.out_of_range = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      per_v <= 1'b0;
      mul_v <= 1'b0;
      out_v <= 1'b0;
    end else if (adv) begin
      per_v <= div_v[QW-1];
      mul_v <= per_v;
      out_v <= mul_v;
    end
    if (adv) begin
      per_r      <= per_next;
      mul_r.per  <= per_r;
      mul_r.prod <= pwmc_pkg::PROD_W'(per_r.m) * pwmc_pkg::PROD_W'(pwmc_pkg::DUTY_RECIP);
      result     <= res_next;
    end
  end

endmodule

[tb/pwm_period_duty_calculator_tb.sv]
// Self-checking testbench for the PWM period/duty calculator.
// Depends on pwmc_pkg for the request/result word types and on the
// pwm_period_duty_calculator top level.
module pwm_period_duty_calculator_tb;

  localparam int RANDOM_WORDS = 1000;
  localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 40;    // well past the time a request takes to reach its result
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_START   = 400;   // receiver cycle at which the long hold-off begins
  localparam int HOLD_LEN     = 300;
  localparam int QUIET_START  = 800;   // receiver window with no idling
  localparam int QUIET_LEN    = 400;
  localparam int EDGE_COUNT   = 16;

  // Frequencies on both sides of every select threshold and of the prescale switch.
  localparam int EDGE_FREQ [EDGE_COUNT] = '{
    7, 8, 15, 16, 30, 31, 61, 62, 122, 123, 244, 245, 488, 489, 7999, 8000
  };

  // Predict timer settings per request word and check result words in order.
  class pwm_setting_board;
    pwmc_pkg::res_t awaiting[$];
    int unsigned    osc_table[8];
    int             mismatches;
    int             results_seen;
    int             zero_words;
    int             clamped_words;
    int             saturated_words;

    function new();
      osc_table = '{31000, 125000, 250000, 500000, 1000000, 2000000, 4000000, 8000000};
      mismatches      = 0;
      results_seen    = 0;
      zero_words      = 0;
      clamped_words   = 0;
      saturated_words = 0;
    endfunction

    function pwmc_pkg::res_t compute_settings(pwmc_pkg::req_t r);
      pwmc_pkg::res_t  s;
      longint unsigned f, d, presc, den, q, period, duty, limit;
      int              code;
      s = '0;
      f = r.frequency_hz;
      d = r.duty_tenths;
      if (f == 0) begin
        s.out_of_range = 1'b1;
        return s;
      end
      if (f < 8000) begin
        s.prescale_code = pwmc_pkg::PRESCALE_16;
        presc = 16;
      end else begin
        s.prescale_code = pwmc_pkg::PRESCALE_1;
        presc = 1;
      end
      // Walk the select thresholds down by halves until f exceeds one.
      code  = 7;
      limit = 488;
      while (code > 0 && !(f > limit)) begin
        limit = limit >> 1;
        code--;
      end
      den = 4 * presc * f;
      q = (2 * longint'(osc_table[code]) + den) / (2 * den);
      if (q == 0) begin
        period = 0;
        s.out_of_range = 1'b1;
      end else if (q - 1 > 255) begin
        period = 255;
        s.out_of_range = 1'b1;
      end else begin
        period = q - 1;
      end
      duty = (4 * (period + 1) * d) / 1000;
      if (duty > 1023) duty = 1023;
      s.clock_select = 3'(code);
      s.period_value = period[7:0];
      s.duty_value   = duty[9:0];
      return s;
    endfunction

    function void note_request(pwmc_pkg::req_t r);
      pwmc_pkg::res_t s;
      s = compute_settings(r);
      if (r.frequency_hz == '0) zero_words++;
      else if (s.out_of_range) clamped_words++;
      if (s.duty_value == pwmc_pkg::DUTY_MAX) saturated_words++;
      awaiting.push_back(s);
    endfunction

    function void check_result(pwmc_pkg::res_t got);
      pwmc_pkg::res_t want;
      bit             bad;
      results_seen++;
      if (awaiting.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result word %h with no request pending", got);
        return;
      end
      want = awaiting.pop_front();
      bad = (got.clock_select  !== want.clock_select)  ||
            (got.prescale_code !== want.prescale_code) ||
            (got.period_value  !== want.period_value)  ||
            (got.duty_value    !== want.duty_value)    ||
            (got.out_of_range  !== want.out_of_range);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result %0d: expected sel=%0d pre=%0d per=%0d duty=%0d oor=%0b",
                   results_seen, want.clock_select, want.prescale_code,
                   want.period_value, want.duty_value, want.out_of_range);
          $display("result %0d: got      sel=%0d pre=%0d per=%0d duty=%0d oor=%0b",
                   results_seen, got.clock_select, got.prescale_code,
                   got.period_value, got.duty_value, got.out_of_range);
        end
      end
    endfunction
  endclass

  logic           clk     = 1'b0;
  logic           rst     = 1'b1;
  logic           push    = 1'b0;
  logic           pop     = 1'b0;
  pwmc_pkg::req_t request = '0;
  logic           full;
  logic           empty;
  pwmc_pkg::res_t result;

  pwm_period_duty_calculator dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  pwm_setting_board board = new();
  int words_sent = 0;
  int directed_words = 0;

  always #2 clk = ~clk;

  // Offer one request word from the falling edge; hold it until it is taken.
  task automatic send_word(input pwmc_pkg::req_t w, input bit may_idle);
    @(negedge clk);
    while (may_idle && $urandom_range(99) < 9) begin
      push = 1'b0;
      @(negedge clk);
    end
    push    = 1'b1;
    request = w;
    do @(posedge clk); while (full);
    board.note_request(w);
    words_sent++;
  endtask

  task automatic send_pair(input int f, input int d);
    pwmc_pkg::req_t w;
    w.frequency_hz = pwmc_pkg::FREQ_W'(f);
    w.duty_tenths  = pwmc_pkg::DUTY_W'(d);
    send_word(w, 1'b1);
    directed_words++;
  endtask

  // Directed words: zero frequency, period clamp, field extremes, every threshold.
  task automatic run_directed();
    int i;
    send_pair(0, 500);
    send_pair(0, 1023);
    send_pair(1, 1000);
    send_pair(1, 1023);
    send_pair(3, 1);
    send_pair(1048575, 0);
    send_pair(1048575, 1000);
    for (i = 0; i < EDGE_COUNT; i++)
      send_pair(EDGE_FREQ[i], (i * 67 + 333) % 1024);
  endtask

  function automatic int pick_frequency();
    int f;
    case ($urandom_range(9))
      0, 1, 2: f = $urandom_range(600, 1);
      3, 4:    f = $urandom_range(9000, 7000);
      5, 6:    f = $urandom_range(1048575, 0);
      7:       f = EDGE_FREQ[$urandom_range(EDGE_COUNT - 1)] + $urandom_range(2) - 1;
      8:       f = $urandom_range(200000, 9000);
      default: f = ($urandom_range(19) == 0) ? 0 : $urandom_range(100, 1);
    endcase
    return f;
  endfunction

  function automatic int pick_duty();
    int d;
    case ($urandom_range(19))
      0:       d = 0;
      1:       d = 1000;
      2, 3:    d = $urandom_range(1023, 1001);
      default: d = $urandom_range(1000, 0);
    endcase
    return d;
  endfunction

  task automatic run_random();
    pwmc_pkg::req_t w;
    int             n;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      w.frequency_hz = pwmc_pkg::FREQ_W'(pick_frequency());
      w.duty_tenths  = pwmc_pkg::DUTY_W'(pick_duty());
      // Drop sender idling across a long stretch in the middle.
      send_word(w, !(n >= 300 && n < 550));
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_directed();
    run_random();
    @(negedge clk);
    push = 1'b0;
    // Wait for every prediction to be matched, then give stragglers time to show.
    while (board.awaiting.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.mismatches += board.awaiting.size();
    $display("Ran %0d request words (%0d directed) with a %0d-cycle output hold-off.",
             words_sent, directed_words, HOLD_LEN);
    $display("Covered %0d zero-frequency, %0d clamped-period, %0d saturated-duty words.",
             board.zero_words, board.clamped_words, board.saturated_words);
    if (board.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Pop result words with random idling, one long hold-off and one quiet window.
  initial begin : result_sink
    int rx_cycle;
    rx_cycle = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
        pop = 1'b0;
      else if (rx_cycle >= QUIET_START && rx_cycle < QUIET_START + QUIET_LEN)
        pop = 1'b1;
      else
        pop = ($urandom_range(99) >= 9);
      @(posedge clk);
      if (pop && !empty) board.check_result(result);
      @(negedge clk);
      rx_cycle++;
    end
  end

  // End the run if no word moves on either side for too long.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) stalled = 0;
      else stalled++;
    end
    $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule
